>>> rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the postfix expression evaluator
// Token classes, operation and status codes, and the front-to-back record.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int unsigned StackDepth = 16;
	localparam int unsigned PtrW       = $clog2(StackDepth);
	localparam int unsigned CntW       = $clog2(StackDepth + 1);
	localparam int unsigned QDepth     = 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// classified token passed from the front to the back
	typedef enum logic [1:0] {
		TK_PUSH = 2'd0,
		TK_OPER = 2'd1,
		TK_NOP  = 2'd2
	} tok_t;

	typedef struct packed {
		tok_t        tok;
		logic [31:0] number;
		op_t         op;
		logic        last;
	} tok_rec_t;

endpackage

>>> rtl/core/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front: token intake
// Classifies incoming tokens and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module rpn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [31:0]       number,
	input  logic [2:0]        operation,
	input  logic              last,
	output logic              q_valid,
	input  logic              q_take,
	output rpn_pkg::tok_rec_t q_rec
);

	rpn_pkg::tok_rec_t mem_q [rpn_pkg::QDepth];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	rpn_pkg::tok_rec_t rec;
	logic              push, pop;

	always_comb begin
		rec.number = number;
		rec.op     = rpn_pkg::op_t'(operation);
		rec.last   = last;
		if (!kind)
			rec.tok = rpn_pkg::TK_PUSH;
		else if (operation > 3'd4)
			rec.tok = rpn_pkg::TK_NOP;
		else
			rec.tok = rpn_pkg::TK_OPER;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_rec    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/core/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu: iterative arithmetic unit
// Add and subtract in one step; multiply, divide and power bit by bit.
// ----------------------------------------------------------------------------
module rpn_alu (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rpn_pkg::op_t   op,
	input  logic [31:0]    a,
	input  logic [31:0]    b,
	output logic           done,
	output logic [31:0]    res,
	output logic           divz
);

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_POWM = 4'b0100,
		A_FIN  = 4'b1000
	} astate_t;

	astate_t     st_q;
	rpn_pkg::op_t op_q;
	logic [5:0]  cnt_q;
	logic [31:0] acc_q, x_q, y_q, rem_q, res_q, base_q, e_q;
	logic        neg_q, divz_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;
	logic [31:0] ua, ub;
	logic [31:0] mul_sum;
	logic        sqr_phase_q;

	assign ua = a[31] ? (~a + 32'd1) : a;
	assign ub = b[31] ? (~b + 32'd1) : b;
	assign rem_sh = {rem_q[30:0], x_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, y_q};
	assign mul_sum = y_q[0] ? (acc_q + x_q) : acc_q;

	assign done = (st_q == A_FIN);
	assign res  = res_q;
	assign divz = divz_q;

	// multiply unit (shift-add) is shared by MUL and by each POW step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
		end else begin
			unique case (st_q)
				A_IDLE: begin
					if (start) begin
						op_q   <= op;
						divz_q <= 1'b0;
						acc_q  <= '0;
						cnt_q  <= '0;
						unique case (op)
							rpn_pkg::OP_ADD: begin
								res_q <= a + b;
								st_q  <= A_FIN;
							end
							rpn_pkg::OP_SUB: begin
								res_q <= a - b;
								st_q  <= A_FIN;
							end
							rpn_pkg::OP_MUL: begin
								x_q  <= a;
								y_q  <= b;
								st_q <= A_MUL;
							end
							rpn_pkg::OP_DIV: begin
								if (b == 32'd0) begin
									divz_q <= 1'b1;
									res_q  <= '0;
									st_q   <= A_FIN;
								end else begin
									x_q   <= ua;
									y_q   <= ub;
									rem_q <= '0;
									neg_q <= a[31] ^ b[31];
									st_q  <= A_MUL;
								end
							end
							default: begin
								if (b[31]) begin
									if (a == 32'd1)
										res_q <= 32'd1;
									else if (a == 32'hFFFF_FFFF)
										res_q <= b[0] ? 32'hFFFF_FFFF : 32'd1;
									else
										res_q <= '0;
									st_q <= A_FIN;
								end else begin
									res_q       <= 32'd1;
									base_q      <= a;
									e_q         <= b;
									sqr_phase_q <= 1'b0;
									st_q        <= A_POWM;
								end
							end
						endcase
					end
				end
				A_MUL: begin
					// 32 steps: multiply (shift-add) or restoring divide
					if (op_q == rpn_pkg::OP_DIV) begin
						x_q <= {x_q[30:0], 1'b0};
						if (!trial[32]) begin
							rem_q <= trial[31:0];
							acc_q <= {acc_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							acc_q <= {acc_q[30:0], 1'b0};
						end
					end else begin
						acc_q <= mul_sum;
						x_q   <= {x_q[30:0], 1'b0};
						y_q   <= {1'b0, y_q[31:1]};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						if (op_q == rpn_pkg::OP_MUL) begin
							res_q <= mul_sum;
							st_q  <= A_FIN;
						end else if (op_q == rpn_pkg::OP_DIV) begin
							res_q <= neg_q
								? ~({acc_q[30:0], ~trial[32]}) + 32'd1
								: {acc_q[30:0], ~trial[32]};
							st_q  <= A_FIN;
						end else begin
							// power: product step finished
							if (sqr_phase_q)
								base_q <= mul_sum;
							else
								res_q <= mul_sum;
							st_q <= A_POWM;
						end
					end
				end
				A_POWM: begin
					// square-and-multiply: one multiply per phase
					acc_q <= '0;
					cnt_q <= '0;
					if (sqr_phase_q) begin
						sqr_phase_q <= 1'b0;
						e_q         <= {1'b0, e_q[31:1]};
						if (e_q[31:1] == 31'd0)
							st_q <= A_FIN;
						else begin
							sqr_phase_q <= 1'b0;
						end
					end else if (e_q == 32'd0) begin
						st_q <= A_FIN;
					end else if (e_q[0] && !sqr_phase_q && cnt_q != 6'd32) begin
						// multiply result by base, then square
						x_q   <= res_q;
						y_q   <= base_q;
						cnt_q <= '0;
						st_q  <= A_MUL;
						e_q   <= {e_q[31:1], 1'b0};
					end else begin
						x_q         <= base_q;
						y_q         <= base_q;
						sqr_phase_q <= 1'b1;
						st_q        <= A_MUL;
					end
				end
				A_FIN: begin
					st_q <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back: stack engine
// Pops queued tokens, keeps the operand stack and sticky status, issues results.
// ----------------------------------------------------------------------------
module rpn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_take,
	input  rpn_pkg::tok_rec_t q_rec,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       value,
	output logic [1:0]        status
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_RDB  = 5'b00010,
		B_RDA  = 5'b00100,
		B_ALU  = 5'b01000,
		B_TOP  = 5'b10000
	} bstate_t;

	bstate_t                    st_q;
	logic [31:0]                stk_q [rpn_pkg::StackDepth];
	logic [rpn_pkg::CntW-1:0]   cnt_q;
	logic [1:0]                 err_q;
	logic [31:0]                rd_q, b_q;
	logic                       last_q;
	rpn_pkg::op_t               op_q;
	logic                       we;
	logic [rpn_pkg::PtrW-1:0]   wa, ra;
	logic [31:0]                wd;
	logic                       ov_valid_q;
	logic [31:0]                ov_value_q;
	logic [1:0]                 ov_status_q;
	logic                       alu_start, alu_done, alu_divz;
	logic [31:0]                alu_res;
	logic [rpn_pkg::CntW-1:0]   cnt_m1, cnt_m2;

	assign cnt_m1 = cnt_q - rpn_pkg::CntW'(1);
	assign cnt_m2 = cnt_q - rpn_pkg::CntW'(2);

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.op     (op_q),
		.a      (rd_q),
		.b      (b_q),
		.done   (alu_done),
		.res    (alu_res),
		.divz   (alu_divz)
	);

	assign value     = ov_value_q;
	assign status    = ov_status_q;
	assign out_valid = ov_valid_q;
	// take a token whenever idle; a waiting result only holds the final step
	assign q_take    = (st_q == B_IDLE) && q_valid;

	// stack memory: one write and one registered read port; the result step also reads the top entry directly
	always_ff @(posedge clk) begin
		if (we)
			stk_q[wa] <= wd;
		rd_q <= stk_q[ra];
	end

	always_comb begin
		we        = 1'b0;
		wa        = cnt_q[rpn_pkg::PtrW-1:0];
		wd        = q_rec.number;
		ra        = cnt_m1[rpn_pkg::PtrW-1:0];
		alu_start = (st_q == B_RDA);
		unique case (st_q)
			B_IDLE: begin
				if (q_take && q_rec.tok == rpn_pkg::TK_PUSH &&
						cnt_q < rpn_pkg::CntW'(rpn_pkg::StackDepth))
					we = 1'b1;
				if (q_take && q_rec.tok == rpn_pkg::TK_PUSH &&
						cnt_q < rpn_pkg::CntW'(rpn_pkg::StackDepth))
					ra = cnt_q[rpn_pkg::PtrW-1:0];
			end
			B_RDB: ra = cnt_m2[rpn_pkg::PtrW-1:0];
			B_ALU: begin
				wa = cnt_q[rpn_pkg::PtrW-1:0];
				wd = alu_res;
				we = alu_done;
				ra = cnt_q[rpn_pkg::PtrW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			cnt_q       <= '0;
			err_q       <= rpn_pkg::ST_OK;
			ov_valid_q  <= 1'b0;
		end else begin
			if (ov_valid_q && !out_stall)
				ov_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (q_take) begin
						last_q <= q_rec.last;
						op_q   <= q_rec.op;
						unique case (q_rec.tok)
							rpn_pkg::TK_PUSH: begin
								if (cnt_q < rpn_pkg::CntW'(rpn_pkg::StackDepth))
									cnt_q <= cnt_q + rpn_pkg::CntW'(1);
								else if (err_q == rpn_pkg::ST_OK)
									err_q <= rpn_pkg::ST_OVER;
								st_q <= q_rec.last ? B_TOP : B_IDLE;
							end
							rpn_pkg::TK_OPER: begin
								if (cnt_q < rpn_pkg::CntW'(2)) begin
									if (err_q == rpn_pkg::ST_OK)
										err_q <= rpn_pkg::ST_UNDER;
									st_q <= q_rec.last ? B_TOP : B_IDLE;
								end else
									st_q <= B_RDB;
							end
							default: st_q <= q_rec.last ? B_TOP : B_IDLE;
						endcase
					end
				end
				B_RDB: begin
					// top operand arrives now; hold it and request the one below
					b_q  <= rd_q;
					st_q <= B_RDA;
				end
				B_RDA: begin
					st_q  <= B_ALU;
					cnt_q <= cnt_m2;
				end
				B_ALU: begin
					if (alu_done) begin
						cnt_q <= cnt_q + rpn_pkg::CntW'(1);
						if (alu_divz && err_q == rpn_pkg::ST_OK)
							err_q <= rpn_pkg::ST_DIVZ;
						st_q <= last_q ? B_TOP : B_IDLE;
					end
				end
				B_TOP: begin
					// wait until the output register is free; the top entry is read directly
					if (!ov_valid_q) begin
						ov_valid_q <= 1'b1;
						if (cnt_q == '0) begin
							ov_value_q  <= '0;
							ov_status_q <= (err_q == rpn_pkg::ST_OK) ? rpn_pkg::ST_UNDER : err_q;
						end else begin
							ov_value_q  <= stk_q[cnt_m1[rpn_pkg::PtrW-1:0]];
							ov_status_q <= err_q;
						end
						cnt_q <= '0;
						err_q <= rpn_pkg::ST_OK;
						st_q  <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: postfix integer expression evaluator
// Pushes number tokens, applies operators to the two top entries, and on the
// last token reports the top of the stack with a sticky status.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------
//  in      | in_valid / in_stall | kind, number, operation, last
//  out     | out_valid/out_stall | value, status
//
//  Multiply and divide run through the 32-step shift-add/restoring unit;
//  power runs up to two such multiplies per exponent bit. A two-entry queue
//  lets the intake hold items while the stack engine works. Reset clears the
//  counts, status and queue at once; the stack memory needs no clearing.
//  A stalled output holds the engine only at the end of the next expression,
//  until the waiting result leaves; the queue then fills and stalls the
//  intake.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] number,
	input  logic [2:0]  operation,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic [1:0]  status
);

	logic              q_valid, q_take;
	rpn_pkg::tok_rec_t q_rec;

	// intake and classify
	rpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.number    (number),
		.operation (operation),
		.last      (last),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_rec     (q_rec)
	);

	// carry out tokens against the stack
	rpn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_rec     (q_rec),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the postfix expression evaluator
// Drives number and operator tokens through a valid/stall intake, predicts
// each end-of-expression result in the bench, and compares value and status.
// ----------------------------------------------------------------------------
module tb;
	import rpn_pkg::*;

	localparam int WatchLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [31:0] number;
	logic [2:0]  operation;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] value;
	logic [1:0]  status;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} answer_t;

	typedef struct {
		logic        kind;
		logic [31:0] number;
		logic [2:0]  operation;
		logic        last;
		logic        typed;
		answer_t     want;
	} token_row_t;

	// bench copy of the evaluator state
	logic [31:0] calc_stack [StackDepth];
	int unsigned calc_count;
	status_t     calc_err;

	answer_t     answers_due [$];
	token_row_t  directed [$];
	int          errors;
	int          quiet_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;
	bit          feeding;

	rpn_stack_evaluator DUT (.*);

	always #5 clk = ~clk;

	// Note the first error only; later ones never replace it.
	function automatic void raise_status(status_t code);
		if (calc_err == ST_OK)
			calc_err = code;
	endfunction

	function automatic logic [31:0] power_wrap(logic [31:0] a, logic [31:0] b);
		logic [31:0] acc;
		logic [31:0] base;
		logic [31:0] e;
		acc  = 32'd1;
		base = a;
		e    = b;
		if (b[31]) begin
			if (a == 32'd1)
				return 32'd1;
			if (a == 32'hFFFF_FFFF)
				return b[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		while (e != 0) begin
			if (e[0])
				acc = acc * base;
			base = base * base;
			e = e >> 1;
		end
		return acc;
	endfunction

	// Advance the bench state by one token; queue the answer on the last one.
	function automatic void evaluate_token(logic k, logic [31:0] num, logic [2:0] op,
			logic lst);
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [31:0] r;
		answer_t ans;
		if (!k) begin
			if (calc_count >= StackDepth)
				raise_status(ST_OVER);
			else begin
				calc_stack[calc_count] = num;
				calc_count++;
			end
		end else if (op <= OP_POW) begin
			if (calc_count < 2)
				raise_status(ST_UNDER);
			else begin
				b = calc_stack[calc_count - 1];
				a = calc_stack[calc_count - 2];
				calc_count -= 2;
				case (op_t'(op))
					OP_ADD: r = a + b;
					OP_SUB: r = a - b;
					OP_MUL: r = a * b;
					OP_DIV: begin
						if (b == 0) begin
							raise_status(ST_DIVZ);
							r = 0;
						end else if (a == 32'sh8000_0000 && b == -32'sd1)
							r = 32'h8000_0000;
						else
							r = a / b;
					end
					default: r = power_wrap(a, b);
				endcase
				calc_stack[calc_count] = r;
				calc_count++;
			end
		end
		if (lst) begin
			if (calc_count == 0) begin
				raise_status(ST_UNDER);
				ans.value = 0;
			end else
				ans.value = calc_stack[calc_count - 1];
			ans.status = calc_err;
			answers_due.push_back(ans);
			calc_count = 0;
			calc_err = ST_OK;
		end
	endfunction

	function automatic void add_row(logic k, logic [31:0] num, logic [2:0] op,
			logic lst, logic typed = 0, logic [31:0] v = 0, status_t st = ST_OK);
		token_row_t row;
		row.kind = k;
		row.number = num;
		row.operation = op;
		row.last = lst;
		row.typed = typed;
		row.want.value = v;
		row.want.status = st;
		directed.push_back(row);
	endfunction

	// Present one token and hold it until the intake takes it.
	task automatic send_token(logic k, logic [31:0] num, logic [2:0] op, logic lst);
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		number    <= num;
		operation <= op;
		last      <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		evaluate_token(k, num, op, lst);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_number();
		case ($urandom_range(5, 0))
			0: return $urandom_range(3, 0);
			1: return -$urandom_range(3, 1);
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(40, 0);
			default: return $urandom;
		endcase
	endfunction

	// A mostly well-formed expression: pushes with operators between them, then operators, ending on last.
	task automatic send_expression();
		int depth;
		int pushes;
		logic [2:0] op;
		pushes = ($urandom_range(9, 0) == 0) ? $urandom_range(17, 14) : $urandom_range(4, 1);
		depth = 0;
		for (int i = 0; i < pushes; i++) begin
			send_token(1'b0, pick_number(), 3'($urandom), 1'b0);
			depth++;
			if (depth >= 2 && $urandom_range(2, 0) == 0) begin
				op = 3'($urandom_range(4, 0));
				if (op == OP_POW && $urandom_range(1, 0))
					send_token(1'b0, $urandom_range(5, 0), 3'd0, 1'b0);
				send_token(1'b1, $urandom, op, 1'b0);
				depth--;
			end
		end
		while ($urandom_range(3, 0) != 0 && depth > 1) begin
			send_token(1'b1, $urandom, 3'($urandom_range(4, 0)), 1'b0);
			depth--;
		end
		// noise: stray operators, reserved codes, or a short stack
		if ($urandom_range(5, 0) == 0)
			send_token(1'b1, $urandom, 3'($urandom_range(7, 0)), 1'b0);
		send_token(1'($urandom_range(1, 0)), pick_number(), 3'($urandom_range(7, 0)), 1'b1);
	endtask

	// Receiver: stall at random, or for a long stretch when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400)
					@(negedge clk);
				hold_off = 0;
			end
			out_stall <= (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// Check each accepted answer against the oldest one due.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected answer value=%0d status=%0d", $time,
					$signed(value), status);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (value !== want.value) begin
					$display("%0t: value expected %0d actual %0d", $time,
						$signed(want.value), $signed(value));
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, status);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (feeding || answers_due.size() != 0)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		kind = 0;
		number = 0;
		operation = 0;
		last = 0;
		errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 0;
		feeding = 1;
		calc_count = 0;
		calc_err = ST_OK;
		foreach (calc_stack[i])
			calc_stack[i] = 0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table: typed answers where they are plain, else predicted
		add_row(0, 0, 0, 1, 1, 0, ST_OK);
		add_row(1, 0, OP_ADD, 1, 1, 0, ST_UNDER);                // last on empty stack
		add_row(0, 32'h7FFF_FFFF, 0, 0);
		add_row(0, 1, 0, 0);
		add_row(1, 32'hFFFF_FFFF, OP_ADD, 1, 1, 32'h8000_0000, ST_OK);
		add_row(0, 32'h8000_0000, 7, 0);
		add_row(0, 32'hFFFF_FFFF, 0, 0);
		add_row(1, 0, OP_DIV, 1, 1, 32'h8000_0000, ST_OK);       // most negative / -1
		add_row(0, 9, 0, 0);
		add_row(0, 0, 0, 0);
		add_row(1, 0, OP_DIV, 1, 1, 0, ST_DIVZ);
		add_row(0, 0, 0, 0);
		add_row(0, 0, 0, 0);
		add_row(1, 0, OP_POW, 1, 1, 1, ST_OK);                   // zero to the zero
		add_row(0, 32'hFFFF_FFFF, 0, 0);
		add_row(0, 32'hFFFF_FFFB, 0, 0);
		add_row(1, 0, OP_POW, 1, 1, 32'hFFFF_FFFF, ST_OK);
		add_row(0, 3, 0, 0);
		add_row(0, 7, 0, 0);
		add_row(1, 0, OP_SUB, 0);
		add_row(0, 32'h1234_5678, 0, 0);
		add_row(1, 0, OP_MUL, 0);
		add_row(1, 0, 5, 0);                                     // reserved code ignored
		add_row(1, 0, 6, 1);
		for (int i = 0; i < StackDepth + 1; i++)                 // push onto a full stack
			add_row(0, i, 0, i == StackDepth, i == StackDepth, StackDepth - 1, ST_OVER);
		foreach (directed[i]) begin
			if (directed[i].typed && answers_due.size() == 0 && calc_count == 0 &&
					calc_err == ST_OK) begin
				// typed rows stand in for the predictor's answer
			end
			send_token(directed[i].kind, directed[i].number, directed[i].operation,
				directed[i].last);
			if (directed[i].typed)
				answers_due[answers_due.size() - 1] = directed[i].want;
		end

		// random phases with the idling swapped and one long receiver stall, then none
		send_idle_pct = 13;
		recv_idle_pct = 48;
		repeat (18)
			send_expression();
		hold_off = 1;
		repeat (6)
			send_expression();
		send_idle_pct = 48;
		recv_idle_pct = 13;
		repeat (18)
			send_expression();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (14)
			send_expression();
		in_valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		feeding = 0;
		repeat (200)
			@(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_front.sv
rtl/core/rpn_alu.sv
rtl/core/rpn_back.sv
rtl/core/rpn_stack_evaluator.sv
bench/tb.sv
